### hdl/qtg_pkg.sv
// Shared types, constants and the sequencer microcode for the quintic trajectory core.
// No dependencies; used by qtg_alu and the top level.
package qtg_pkg;

    localparam int TIME_FRAC_BITS = 16;
    localparam int NORM_BITS      = 32;

    localparam int SHIFT_W = 6;
    localparam int CNT_W   = 7;
    localparam int PC_W    = 6;
    localparam int IMM_W   = 5;

    localparam logic [SHIFT_W-1:0] SH_NONE = '0;
    localparam logic [SHIFT_W-1:0] SH_G    = SHIFT_W'(TIME_FRAC_BITS);
    localparam logic [SHIFT_W-1:0] SH_GG   = SHIFT_W'(2 * TIME_FRAC_BITS);
    localparam logic [SHIFT_W-1:0] SH_G2   = SHIFT_W'(2 * TIME_FRAC_BITS + 1);
    localparam logic [SHIFT_W-1:0] SH_N    = SHIFT_W'(NORM_BITS);

    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_ADD
    } alu_op_t;

    typedef enum logic [4:0] {
        SRC_DUR, SRC_TIN, SRC_T2, SRC_TT,
        SRC_S, SRC_S2, SRC_S3, SRC_S4, SRC_S5,
        SRC_TMP, SRC_D,
        SRC_CA, SRC_CB, SRC_CC,
        SRC_POS, SRC_VEL, SRC_ACC,
        SRC_P0, SRC_V0, SRC_A0,
        SRC_AH, SRC_AV, SRC_AA,
        SRC_BH, SRC_BV, SRC_BA,
        SRC_CH, SRC_CV, SRC_CAA,
        SRC_IMM
    } src_t;

    typedef enum logic [3:0] {
        DST_T2, DST_TT,
        DST_S, DST_S2, DST_S3, DST_S4, DST_S5,
        DST_TMP, DST_D,
        DST_CA, DST_CB, DST_CC,
        DST_POS, DST_VEL, DST_ACC
    } dst_t;

    typedef struct packed {
        alu_op_t            op;
        dst_t               dst;
        src_t               src_a;
        src_t               src_b;
        logic [SHIFT_W-1:0] shift;
        logic               negb;
        logic [IMM_W-1:0]   imm;
    } instr_t;

    typedef struct packed {
        logic               start;
        alu_op_t            op;
        logic [SHIFT_W-1:0] shift;
        logic               negb;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } alu_rsp_t;

    localparam logic [PC_W-1:0] PC_COEF_LAST = 6'd12;
    localparam logic [PC_W-1:0] PC_EVAL      = 6'd13;
    localparam logic [PC_W-1:0] PC_LAST      = 6'd50;

    function automatic instr_t mk(alu_op_t op, dst_t dst, src_t a, src_t b,
                                  logic [SHIFT_W-1:0] sh, logic negb, logic [IMM_W-1:0] imm);
        instr_t i;
        i.op    = op;
        i.dst   = dst;
        i.src_a = a;
        i.src_b = b;
        i.shift = sh;
        i.negb  = negb;
        i.imm   = imm;
        return i;
    endfunction

    // Steps 0..12 rebuild the coefficients, 13..50 evaluate one sample.
    function automatic instr_t ucode(logic [PC_W-1:0] pc);
        instr_t i;
        i = mk(ALU_ADD, DST_TMP, SRC_TMP, SRC_TMP, SH_NONE, 1'b0, '0);
        unique case (pc)
            6'd0:  i = mk(ALU_MUL, DST_T2,  SRC_DUR, SRC_DUR, SH_NONE, 1'b0, '0);
            6'd1:  i = mk(ALU_MUL, DST_TMP, SRC_AV,  SRC_DUR, SH_G,    1'b0, '0);
            6'd2:  i = mk(ALU_ADD, DST_CA,  SRC_AH,  SRC_TMP, SH_NONE, 1'b1, '0);
            6'd3:  i = mk(ALU_MUL, DST_TMP, SRC_AA,  SRC_T2,  SH_G2,   1'b0, '0);
            6'd4:  i = mk(ALU_ADD, DST_CA,  SRC_CA,  SRC_TMP, SH_NONE, 1'b1, '0);
            6'd5:  i = mk(ALU_MUL, DST_TMP, SRC_BV,  SRC_DUR, SH_G,    1'b0, '0);
            6'd6:  i = mk(ALU_ADD, DST_CB,  SRC_BH,  SRC_TMP, SH_NONE, 1'b0, '0);
            6'd7:  i = mk(ALU_MUL, DST_TMP, SRC_BA,  SRC_T2,  SH_G2,   1'b0, '0);
            6'd8:  i = mk(ALU_ADD, DST_CB,  SRC_CB,  SRC_TMP, SH_NONE, 1'b0, '0);
            6'd9:  i = mk(ALU_MUL, DST_TMP, SRC_CV,  SRC_DUR, SH_G,    1'b0, '0);
            6'd10: i = mk(ALU_ADD, DST_CC,  SRC_CH,  SRC_TMP, SH_NONE, 1'b1, '0);
            6'd11: i = mk(ALU_MUL, DST_TMP, SRC_CAA, SRC_T2,  SH_G2,   1'b0, '0);
            6'd12: i = mk(ALU_ADD, DST_CC,  SRC_CC,  SRC_TMP, SH_NONE, 1'b1, '0);
            6'd13: i = mk(ALU_DIV, DST_S,   SRC_TIN, SRC_DUR, SH_N,    1'b0, '0);
            6'd14: i = mk(ALU_MUL, DST_S2,  SRC_S,   SRC_S,   SH_N,    1'b0, '0);
            6'd15: i = mk(ALU_MUL, DST_S3,  SRC_S2,  SRC_S,   SH_N,    1'b0, '0);
            6'd16: i = mk(ALU_MUL, DST_S4,  SRC_S3,  SRC_S,   SH_N,    1'b0, '0);
            6'd17: i = mk(ALU_MUL, DST_S5,  SRC_S4,  SRC_S,   SH_N,    1'b0, '0);
            6'd18: i = mk(ALU_MUL, DST_TMP, SRC_V0,  SRC_TIN, SH_G,    1'b0, '0);
            6'd19: i = mk(ALU_ADD, DST_POS, SRC_P0,  SRC_TMP, SH_NONE, 1'b0, '0);
            6'd20: i = mk(ALU_MUL, DST_TT,  SRC_TIN, SRC_TIN, SH_NONE, 1'b0, '0);
            6'd21: i = mk(ALU_MUL, DST_TMP, SRC_A0,  SRC_TT,  SH_G2,   1'b0, '0);
            6'd22: i = mk(ALU_ADD, DST_POS, SRC_POS, SRC_TMP, SH_NONE, 1'b0, '0);
            6'd23: i = mk(ALU_MUL, DST_TMP, SRC_CA,  SRC_S3,  SH_N,    1'b0, '0);
            6'd24: i = mk(ALU_ADD, DST_POS, SRC_POS, SRC_TMP, SH_NONE, 1'b0, '0);
            6'd25: i = mk(ALU_MUL, DST_TMP, SRC_CB,  SRC_S4,  SH_N,    1'b0, '0);
            6'd26: i = mk(ALU_ADD, DST_POS, SRC_POS, SRC_TMP, SH_NONE, 1'b0, '0);
            6'd27: i = mk(ALU_MUL, DST_TMP, SRC_CC,  SRC_S5,  SH_N,    1'b0, '0);
            6'd28: i = mk(ALU_ADD, DST_POS, SRC_POS, SRC_TMP, SH_NONE, 1'b0, '0);
            6'd29: i = mk(ALU_MUL, DST_TMP, SRC_CA,  SRC_IMM, SH_NONE, 1'b0, 5'd3);
            6'd30: i = mk(ALU_MUL, DST_D,   SRC_TMP, SRC_S2,  SH_N,    1'b0, '0);
            6'd31: i = mk(ALU_MUL, DST_TMP, SRC_CB,  SRC_IMM, SH_NONE, 1'b0, 5'd4);
            6'd32: i = mk(ALU_MUL, DST_TMP, SRC_TMP, SRC_S3,  SH_N,    1'b0, '0);
            6'd33: i = mk(ALU_ADD, DST_D,   SRC_D,   SRC_TMP, SH_NONE, 1'b0, '0);
            6'd34: i = mk(ALU_MUL, DST_TMP, SRC_CC,  SRC_IMM, SH_NONE, 1'b0, 5'd5);
            6'd35: i = mk(ALU_MUL, DST_TMP, SRC_TMP, SRC_S4,  SH_N,    1'b0, '0);
            6'd36: i = mk(ALU_ADD, DST_D,   SRC_D,   SRC_TMP, SH_NONE, 1'b0, '0);
            6'd37: i = mk(ALU_MUL, DST_TMP, SRC_A0,  SRC_TIN, SH_G,    1'b0, '0);
            6'd38: i = mk(ALU_ADD, DST_VEL, SRC_V0,  SRC_TMP, SH_NONE, 1'b0, '0);
            6'd39: i = mk(ALU_DIV, DST_TMP, SRC_D,   SRC_DUR, SH_G,    1'b0, '0);
            6'd40: i = mk(ALU_ADD, DST_VEL, SRC_VEL, SRC_TMP, SH_NONE, 1'b0, '0);
            6'd41: i = mk(ALU_MUL, DST_TMP, SRC_CA,  SRC_IMM, SH_NONE, 1'b0, 5'd6);
            6'd42: i = mk(ALU_MUL, DST_D,   SRC_TMP, SRC_S,   SH_N,    1'b0, '0);
            6'd43: i = mk(ALU_MUL, DST_TMP, SRC_CB,  SRC_IMM, SH_NONE, 1'b0, 5'd12);
            6'd44: i = mk(ALU_MUL, DST_TMP, SRC_TMP, SRC_S2,  SH_N,    1'b0, '0);
            6'd45: i = mk(ALU_ADD, DST_D,   SRC_D,   SRC_TMP, SH_NONE, 1'b0, '0);
            6'd46: i = mk(ALU_MUL, DST_TMP, SRC_CC,  SRC_IMM, SH_NONE, 1'b0, 5'd20);
            6'd47: i = mk(ALU_MUL, DST_TMP, SRC_TMP, SRC_S3,  SH_N,    1'b0, '0);
            6'd48: i = mk(ALU_ADD, DST_D,   SRC_D,   SRC_TMP, SH_NONE, 1'b0, '0);
            6'd49: i = mk(ALU_DIV, DST_TMP, SRC_D,   SRC_T2,  SH_GG,   1'b0, '0);
            6'd50: i = mk(ALU_ADD, DST_ACC, SRC_A0,  SRC_TMP, SH_NONE, 1'b0, '0);
            default: i = mk(ALU_ADD, DST_TMP, SRC_TMP, SRC_TMP, SH_NONE, 1'b0, '0);
        endcase
        return i;
    endfunction

endpackage

### hdl/qtg_alu.sv
// Shared arithmetic unit: saturating multiply-round-shift, restoring divide, saturating add.
// Depends on qtg_pkg. One operation at a time, done pulses with the result.
module qtg_alu import qtg_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  alu_req_t           req,
    input  logic signed [63:0] opa,
    input  logic signed [63:0] opb,
    output logic signed [63:0] result,
    output alu_rsp_t           rsp
);

    typedef enum logic [2:0] {
        AL_IDLE, AL_MUL, AL_RND, AL_MFIN, AL_DIV, AL_DFIN
    } al_state_t;

    localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MIN = -65'sh0_7FFF_FFFF_FFFF_FFFF;

    al_state_t          state_reg;
    logic               done_reg;
    logic               ovf_reg;
    logic signed [63:0] result_reg;
    logic [63:0]        ma_reg, mb_reg;
    logic               neg_reg;
    logic [127:0]       prod_reg;
    logic [1:0]         k_reg;
    logic [SHIFT_W-1:0] sh_reg;
    logic [63:0]        dvd_reg, dsr_reg, rem_reg, quo_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [31:0]        pa, pb;
    logic [63:0]        pp;
    logic [127:0]       pp_sh, rnd_add, q_sh;
    logic               mul_ovf;
    logic [63:0]        mul_mag;
    logic [63:0]        rn, rem_nx;
    logic               ge;
    logic [64:0]        q_rnd;
    logic               d_ovf;
    logic [63:0]        d_mag;
    logic signed [64:0] ax, bx, sum;
    logic signed [63:0] add_res;
    logic               add_ovf;
    logic [63:0]        abs_a, abs_b;

    function automatic logic signed [63:0] apply_sign(logic [63:0] mag, logic neg);
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    always_comb begin
        abs_a = opa[63] ? 64'(-opa) : 64'(opa);
        abs_b = opb[63] ? 64'(-opb) : 64'(opb);

        // 32x32 partial products, one a cycle
        pa = k_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        pb = k_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp = pa * pb;
        case (k_reg)
            2'd0:    pp_sh = {64'b0, pp};
            2'd3:    pp_sh = {pp, 64'b0};
            default: pp_sh = {32'b0, pp, 32'b0};
        endcase
        rnd_add = (sh_reg == SH_NONE) ? 128'b0 : (128'b1 << (sh_reg - SHIFT_W'(1)));
        q_sh    = prod_reg >> sh_reg;
        mul_ovf = |q_sh[127:63];
        mul_mag = mul_ovf ? MAG_MAX : q_sh[63:0];

        rn     = {rem_reg[62:0], dvd_reg[63]};
        ge     = rn >= dsr_reg;
        rem_nx = ge ? rn - dsr_reg : rn;
        q_rnd  = {1'b0, quo_reg} + 65'({rem_reg, 1'b0} >= {1'b0, dsr_reg});
        d_ovf  = q_rnd > {1'b0, MAG_MAX};
        d_mag  = d_ovf ? MAG_MAX : q_rnd[63:0];

        ax  = {opa[63], opa};
        bx  = req.negb ? -{opb[63], opb} : {opb[63], opb};
        sum = ax + bx;
        add_ovf = (sum > SUM_MAX) || (sum < SUM_MIN);
        if (sum > SUM_MAX) begin
            add_res = $signed(MAG_MAX);
        end else if (sum < SUM_MIN) begin
            add_res = -$signed(MAG_MAX);
        end else begin
            add_res = sum[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                AL_IDLE: begin
                    if (req.start) begin
                        unique case (req.op)
                            ALU_MUL: begin
                                ma_reg    <= abs_a;
                                mb_reg    <= abs_b;
                                neg_reg   <= opa[63] ^ opb[63];
                                prod_reg  <= '0;
                                k_reg     <= '0;
                                sh_reg    <= req.shift;
                                state_reg <= AL_MUL;
                            end
                            ALU_DIV: begin
                                dvd_reg   <= abs_a;
                                neg_reg   <= opa[63];
                                dsr_reg   <= opb;
                                rem_reg   <= '0;
                                quo_reg   <= '0;
                                cnt_reg   <= CNT_W'(64) + CNT_W'(req.shift);
                                state_reg <= AL_DIV;
                            end
                            ALU_ADD: begin
                                result_reg <= add_res;
                                ovf_reg    <= add_ovf;
                                done_reg   <= 1'b1;
                            end
                            default: begin
                                result_reg <= '0;
                                ovf_reg    <= 1'b0;
                                done_reg   <= 1'b1;
                            end
                        endcase
                    end
                end
                AL_MUL: begin
                    prod_reg <= prod_reg + pp_sh;
                    k_reg    <= k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        state_reg <= AL_RND;
                    end
                end
                AL_RND: begin
                    prod_reg  <= prod_reg + rnd_add;
                    state_reg <= AL_MFIN;
                end
                AL_MFIN: begin
                    result_reg <= apply_sign(mul_mag, neg_reg);
                    ovf_reg    <= mul_ovf;
                    done_reg   <= 1'b1;
                    state_reg  <= AL_IDLE;
                end
                AL_DIV: begin
                    // quotient about to outgrow the signed range: give up saturated
                    if (quo_reg[63:62] != 2'b00) begin
                        result_reg <= apply_sign(MAG_MAX, neg_reg);
                        ovf_reg    <= 1'b1;
                        done_reg   <= 1'b1;
                        state_reg  <= AL_IDLE;
                    end else begin
                        dvd_reg <= {dvd_reg[62:0], 1'b0};
                        rem_reg <= rem_nx;
                        quo_reg <= {quo_reg[62:0], ge};
                        cnt_reg <= cnt_reg - CNT_W'(1);
                        if (cnt_reg == CNT_W'(1)) begin
                            state_reg <= AL_DFIN;
                        end
                    end
                end
                AL_DFIN: begin
                    result_reg <= apply_sign(d_mag, neg_reg);
                    ovf_reg    <= d_ovf;
                    done_reg   <= 1'b1;
                    state_reg  <= AL_IDLE;
                end
                default: state_reg <= AL_IDLE;
            endcase
        end
    end

    assign result   = result_reg;
    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;

endmodule

### hdl/quintic_trajectory_generator_core.sv
// Quintic point-to-point trajectory core: APB register file, microcode sequencer, output stage.
// Depends on qtg_pkg and qtg_alu.
//
// A sample beat (unsigned Q8.16 time) returns position, velocity and acceleration
// (signed Q16.16) of the quintic move set up in the registers, plus a clamped flag.
// All microcode arithmetic runs through one shared unit; each microcode step has an issue
// state and a writeback wait. A multiply runs on a single 32x32 multiplier (four partial
// products, round, saturate). A divide produces one quotient bit a cycle, or stops early
// when it saturates. A sample runs through the sequencer and then the output register, and
// its time is dominated by the three divides. The first sample after reset or after a write
// to one of the seven configuration registers first rebuilds the coefficients. s_ready is
// high only between samples; a finished result sits in the output register until taken.
module quintic_trajectory_generator_core import qtg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_sample_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_position,
    output logic [31:0] m_velocity,
    output logic [31:0] m_acceleration,
    output logic        m_clamped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        ST_IDLE, ST_ISSUE, ST_WAIT, ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        REG_START_POS, REG_START_VEL, REG_START_ACC,
        REG_END_POS, REG_END_VEL, REG_END_ACC,
        REG_DURATION, REG_NONE
    } reg_idx_t;

    localparam logic signed [63:0] OUT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] OUT_MIN = -64'sh0000_0000_8000_0000;

    state_t             state_reg;
    logic [PC_W-1:0]    pc_reg;
    logic               coef_valid_reg;
    logic               ovf_reg;
    logic [23:0]        tin_reg;

    logic signed [31:0] p0_reg, v0_reg, a0_reg, p1_reg, v1_reg, a1_reg;
    logic [23:0]        dur_reg;

    logic signed [63:0] t2_reg, tt_reg, s_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    logic signed [63:0] tmp_reg, d_reg, ca_reg, cb_reg, cc_reg;
    logic signed [63:0] pos_reg, vel_reg, acc_reg;

    logic               m_valid_reg;
    logic [31:0]        m_position_reg, m_velocity_reg, m_acceleration_reg;
    logic               m_clamped_reg;

    instr_t             instr;
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;
    logic signed [63:0] alu_a, alu_b, alu_y;

    logic signed [63:0] p0x, v0x, a0x, p1x, v1x, a1x, h;
    logic signed [63:0] lin_ah, lin_av, lin_aa, lin_bh, lin_bv, lin_ba;
    logic signed [63:0] lin_ch, lin_cv, lin_caa;
    logic [23:0]        dur_eff;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;
    logic               pos_hi, pos_lo, vel_hi, vel_lo, acc_hi, acc_lo;

    // small constant combinations of the boundary values
    always_comb begin
        p0x = {{32{p0_reg[31]}}, p0_reg};
        v0x = {{32{v0_reg[31]}}, v0_reg};
        a0x = {{32{a0_reg[31]}}, a0_reg};
        p1x = {{32{p1_reg[31]}}, p1_reg};
        v1x = {{32{v1_reg[31]}}, v1_reg};
        a1x = {{32{a1_reg[31]}}, a1_reg};
        h       = p1x - p0x;
        lin_ah  = (h <<< 3) + (h <<< 1);
        lin_bh  = h - (h <<< 4);
        lin_ch  = (h <<< 2) + (h <<< 1);
        lin_av  = (v0x <<< 2) + (v0x <<< 1) + (v1x <<< 2);
        lin_bv  = (v0x <<< 3) + (v1x <<< 3) - v1x;
        lin_cv  = (v0x <<< 1) + v0x + (v1x <<< 1) + v1x;
        lin_aa  = (a0x <<< 1) + a0x - a1x;
        lin_ba  = (a0x <<< 1) + a0x - (a1x <<< 1);
        lin_caa = a0x - a1x;
        dur_eff = (dur_reg == 24'd0) ? 24'd1 : dur_reg;
    end

    function automatic logic signed [63:0] operand(src_t src, logic [IMM_W-1:0] imm);
        logic signed [63:0] v;
        case (src)
            SRC_DUR: v = {40'b0, dur_eff};
            SRC_TIN: v = {40'b0, tin_reg};
            SRC_T2:  v = t2_reg;
            SRC_TT:  v = tt_reg;
            SRC_S:   v = s_reg;
            SRC_S2:  v = s2_reg;
            SRC_S3:  v = s3_reg;
            SRC_S4:  v = s4_reg;
            SRC_S5:  v = s5_reg;
            SRC_TMP: v = tmp_reg;
            SRC_D:   v = d_reg;
            SRC_CA:  v = ca_reg;
            SRC_CB:  v = cb_reg;
            SRC_CC:  v = cc_reg;
            SRC_POS: v = pos_reg;
            SRC_VEL: v = vel_reg;
            SRC_ACC: v = acc_reg;
            SRC_P0:  v = p0x;
            SRC_V0:  v = v0x;
            SRC_A0:  v = a0x;
            SRC_AH:  v = lin_ah;
            SRC_AV:  v = lin_av;
            SRC_AA:  v = lin_aa;
            SRC_BH:  v = lin_bh;
            SRC_BV:  v = lin_bv;
            SRC_BA:  v = lin_ba;
            SRC_CH:  v = lin_ch;
            SRC_CV:  v = lin_cv;
            SRC_CAA: v = lin_caa;
            SRC_IMM: v = {{(64-IMM_W){1'b0}}, imm};
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        instr         = ucode(pc_reg);
        alu_a         = operand(instr.src_a, instr.imm);
        alu_b         = operand(instr.src_b, instr.imm);
        alu_req.start = (state_reg == ST_ISSUE);
        alu_req.op    = instr.op;
        alu_req.shift = instr.shift;
        alu_req.negb  = instr.negb;
    end

    qtg_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (alu_a),
        .opb     (alu_b),
        .result  (alu_y),
        .rsp     (alu_rsp)
    );

    always_comb begin
        pos_hi = pos_reg > OUT_MAX;
        pos_lo = pos_reg < OUT_MIN;
        vel_hi = vel_reg > OUT_MAX;
        vel_lo = vel_reg < OUT_MIN;
        acc_hi = acc_reg > OUT_MAX;
        acc_lo = acc_reg < OUT_MIN;
    end

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pc_reg         <= '0;
            coef_valid_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            p0_reg         <= '0;
            v0_reg         <= '0;
            a0_reg         <= '0;
            p1_reg         <= '0;
            v1_reg         <= '0;
            a1_reg         <= '0;
            dur_reg        <= 24'(1 << TIME_FRAC_BITS);
            ca_reg         <= '0;
            cb_reg         <= '0;
            cc_reg         <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        tin_reg   <= s_sample_time;
                        ovf_reg   <= 1'b0;
                        pc_reg    <= coef_valid_reg ? PC_EVAL : '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (alu_rsp.done) begin
                        ovf_reg <= ovf_reg | alu_rsp.ovf;
                        case (instr.dst)
                            DST_T2:  t2_reg  <= alu_y;
                            DST_TT:  tt_reg  <= alu_y;
                            DST_S:   s_reg   <= alu_y;
                            DST_S2:  s2_reg  <= alu_y;
                            DST_S3:  s3_reg  <= alu_y;
                            DST_S4:  s4_reg  <= alu_y;
                            DST_S5:  s5_reg  <= alu_y;
                            DST_TMP: tmp_reg <= alu_y;
                            DST_D:   d_reg   <= alu_y;
                            DST_CA:  ca_reg  <= alu_y;
                            DST_CB:  cb_reg  <= alu_y;
                            DST_CC:  cc_reg  <= alu_y;
                            DST_POS: pos_reg <= alu_y;
                            DST_VEL: vel_reg <= alu_y;
                            DST_ACC: acc_reg <= alu_y;
                            default: tmp_reg <= alu_y;
                        endcase
                        if (pc_reg == PC_COEF_LAST) begin
                            coef_valid_reg <= 1'b1;
                        end
                        if (pc_reg == PC_LAST) begin
                            state_reg <= ST_FINISH;
                        end else begin
                            pc_reg    <= pc_reg + PC_W'(1);
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_position_reg     <= pos_hi ? 32'h7FFF_FFFF :
                                              pos_lo ? 32'h8000_0000 : pos_reg[31:0];
                        m_velocity_reg     <= vel_hi ? 32'h7FFF_FFFF :
                                              vel_lo ? 32'h8000_0000 : vel_reg[31:0];
                        m_acceleration_reg <= acc_hi ? 32'h7FFF_FFFF :
                                              acc_lo ? 32'h8000_0000 : acc_reg[31:0];
                        m_clamped_reg      <= ovf_reg | pos_hi | pos_lo | vel_hi | vel_lo
                                              | acc_hi | acc_lo;
                        m_valid_reg        <= 1'b1;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            // register writes must only arrive while idle; the user is bound to this, the block does not enforce it
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_START_POS: p0_reg  <= pwdata;
                    REG_START_VEL: v0_reg  <= pwdata;
                    REG_START_ACC: a0_reg  <= pwdata;
                    REG_END_POS:   p1_reg  <= pwdata;
                    REG_END_VEL:   v1_reg  <= pwdata;
                    REG_END_ACC:   a1_reg  <= pwdata;
                    REG_DURATION:  dur_reg <= pwdata[23:0];
                    default: ;
                endcase
                if (cfg_idx != REG_NONE) begin
                    coef_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_START_POS: prdata = p0_reg;
            REG_START_VEL: prdata = v0_reg;
            REG_START_ACC: prdata = a0_reg;
            REG_END_POS:   prdata = p1_reg;
            REG_END_VEL:   prdata = v1_reg;
            REG_END_ACC:   prdata = a1_reg;
            REG_DURATION:  prdata = {8'b0, dur_reg};
            default:       prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_position     = m_position_reg;
    assign m_velocity     = m_velocity_reg;
    assign m_acceleration = m_acceleration_reg;
    assign m_clamped      = m_clamped_reg;

endmodule

### hdl/qtg_checker.sv
// Port-level assertions for the quintic trajectory core, bound to the top level.
// Depends on qtg_pkg only through the bound design.
module qtg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_position,
    input logic [31:0] m_velocity,
    input logic [31:0] m_acceleration,
    input logic        m_clamped,
    input logic        pready
);

    // busy right after taking a sample beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("core ready again right after accepting a sample");

    // a result cannot appear in the cycle after a sample is taken
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared too soon after a sample");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_position) && $stable(m_velocity)
                                   && $stable(m_acceleration) && $stable(m_clamped)))
        else $error("stalled result beat changed");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

endmodule

bind quintic_trajectory_generator_core qtg_checker u_qtg_checker (.*);
